// ===== hw/rtl/aimdrto_pkg.sv =====
// ----------------------------------------------------------------------------
// aimdrto_pkg
// Shared types and constants for the AIMD window / RTO estimator.
// ----------------------------------------------------------------------------
package aimdrto_pkg;

    // Item kinds
    localparam logic [1:0] KIND_ACK        = 2'd0;
    localparam logic [1:0] KIND_RESEND     = 2'd1;
    localparam logic [1:0] KIND_RTO_UPDATE = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ADD_STEP        = 3'd0;
    localparam logic [2:0] CFG_DECREASE_SHIFT  = 3'd1;
    localparam logic [2:0] CFG_WINDOW_BOUND    = 3'd2;
    localparam logic [2:0] CFG_FIRST_RTO_FLOOR = 3'd3;
    localparam logic [2:0] CFG_LATER_RTO_FLOOR = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Window limits, Q8.8, and RTT limit in ms
    localparam logic [15:0] WIN_ONE = 16'd256;
    localparam logic [15:0] WIN_MAX = 16'hFFFF;
    localparam logic [15:0] RTT_MAX = 16'hFFFF;

    // Reset values of the configuration registers
    localparam logic [7:0]  ADD_STEP_RST        = 8'd26;
    localparam logic [2:0]  DECREASE_SHIFT_RST  = 3'd1;
    localparam logic [7:0]  WINDOW_BOUND_RST    = 8'd12;
    localparam logic [15:0] FIRST_RTO_FLOOR_RST = 16'd100;
    localparam logic [15:0] LATER_RTO_FLOOR_RST = 16'd10;

    typedef struct packed {
        logic [7:0]  add_step;
        logic [2:0]  decrease_shift;
        logic [7:0]  window_bound;
        logic [15:0] first_rto_floor;
        logic [15:0] later_rto_floor;
    } t_cfg;

    typedef struct packed {
        logic [15:0] window;        // Q8.8
        logic [15:0] last_rtt;      // ms
        logic [23:0] smoothed_rtt;  // Q16.8
        logic [23:0] rtt_variance;  // Q16.8
        logic [26:0] timeout_value; // Q19.8
        logic        first_update;
    } t_state;

endpackage

// ===== hw/rtl/aimdrto_core.sv =====
// ----------------------------------------------------------------------------
// aimdrto_core
// Next-state logic for one transaction: RTT measure, AIMD window update
// and Jacobson/Karels estimator step.
// ----------------------------------------------------------------------------
module aimdrto_core (
    input  aimdrto_pkg::t_cfg   i_cfg,
    input  aimdrto_pkg::t_state i_state,
    input  logic [1:0]          i_kind,
    input  logic [31:0]         i_send_time,
    input  logic [31:0]         i_now_time,
    output aimdrto_pkg::t_state o_state
);
    import aimdrto_pkg::*;

    logic [32:0] rtt_diff;
    logic [15:0] rtt_meas;
    logic [15:0] bound_q8;
    logic        below_bound;
    logic        rtt_ok;
    logic [16:0] grow_sum;
    logic [15:0] win_grow;
    logic [15:0] win_shr;
    logic [15:0] win_shrink;
    logic [23:0] r_cur;
    logic [23:0] abs_diff;
    logic [25:0] var_sum;
    logic [26:0] srtt_sum;
    logic [23:0] srtt_new;
    logic [23:0] var_new;
    logic [15:0] floor_sel;
    logic [25:0] var4;
    logic [25:0] flo;
    logic [25:0] var_term;

    // RTT measure, clamped to 0..65535
    always_comb begin
        rtt_diff = {1'b0, i_now_time} - {1'b0, i_send_time};
        if (rtt_diff[32]) begin
            rtt_meas = '0;
        end else if (rtt_diff[31:16] != 16'd0) begin
            rtt_meas = RTT_MAX;
        end else begin
            rtt_meas = rtt_diff[15:0];
        end
    end

    // Window growth and decrease candidates
    always_comb begin
        bound_q8    = {i_cfg.window_bound, 8'h00};
        below_bound = i_state.window < bound_q8;
        rtt_ok      = {3'b000, rtt_meas, 8'h00} < i_state.timeout_value;
        grow_sum    = {1'b0, i_state.window} + {9'd0, i_cfg.add_step};
        win_grow    = grow_sum[16] ? WIN_MAX : grow_sum[15:0];
        win_shr     = i_state.window >> i_cfg.decrease_shift;
        win_shrink  = (win_shr < WIN_ONE) ? WIN_ONE : win_shr;
    end

    // Estimator step, uses the stored last RTT
    always_comb begin
        r_cur    = {i_state.last_rtt, 8'h00};
        abs_diff = (r_cur >= i_state.smoothed_rtt) ? (r_cur - i_state.smoothed_rtt)
                                                   : (i_state.smoothed_rtt - r_cur);
        var_sum  = {2'b00, i_state.rtt_variance} + {1'b0, i_state.rtt_variance, 1'b0}
                 + {2'b00, abs_diff};
        srtt_sum = {i_state.smoothed_rtt, 3'b000} - {3'b000, i_state.smoothed_rtt}
                 + {3'b000, r_cur};
        if (i_state.first_update) begin
            srtt_new  = r_cur;
            var_new   = {1'b0, i_state.last_rtt, 7'd0};
            floor_sel = i_cfg.first_rto_floor;
        end else begin
            srtt_new  = srtt_sum[26:3];
            var_new   = var_sum[25:2];
            floor_sel = i_cfg.later_rto_floor;
        end
        var4     = {var_new, 2'b00};
        flo      = {2'b00, floor_sel, 8'h00};
        var_term = (var4 > flo) ? var4 : flo;
    end

    // Select by kind
    always_comb begin
        o_state = i_state;
        case (i_kind)
            KIND_ACK: begin
                o_state.last_rtt = rtt_meas;
                if (rtt_ok && below_bound) begin
                    o_state.window = win_grow;
                end else if (!below_bound) begin
                    o_state.window = win_shrink;
                end
            end
            KIND_RESEND: begin
                o_state.last_rtt = rtt_meas;
                o_state.window   = win_shrink;
            end
            KIND_RTO_UPDATE: begin
                o_state.smoothed_rtt  = srtt_new;
                o_state.rtt_variance  = var_new;
                o_state.timeout_value = {3'b000, srtt_new} + {1'b0, var_term};
                o_state.first_update  = 1'b0;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

// ===== hw/rtl/aimd_window_rto_estimator.sv =====
// ----------------------------------------------------------------------------
// aimd_window_rto_estimator
// Sender congestion controller: Q8.8 AIMD window plus Jacobson/Karels RTO.
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  --------+------------------------------+----------------------------------
//  in      | i_in_valid  / o_in_stall     | i_kind, i_send_time, i_now_time
//  out     | o_out_valid / i_out_stall    | o_window_q8, o_rto_ms, o_rtt_ms
//  cfg     | i_cfg_wr_en                  | i_cfg_index, i_cfg_wr_data
//
// One transaction per cycle while the output is not stalled; an accepted item
// passes the input register and then the result register. The state update is
// done as the item moves from the input register into the result register.
// Synchronous active-low reset initialises state, configuration registers and valids.
// A stall on the output holds the result register; the input register then
// holds and o_in_stall rises only while it is occupied.
// ----------------------------------------------------------------------------
module aimd_window_rto_estimator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [aimdrto_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [aimdrto_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_kind,
    input  logic [31:0]                         i_send_time,
    input  logic [31:0]                         i_now_time,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [15:0]                         o_window_q8,
    output logic [18:0]                         o_rto_ms,
    output logic [15:0]                         o_rtt_ms
);
    import aimdrto_pkg::*;

    t_cfg        r_cfg;
    t_state      r_state;
    t_state      n_state;
    logic        r_in_valid;
    logic [1:0]  r_kind;
    logic [31:0] r_send_time;
    logic [31:0] r_now_time;
    logic        r_out_valid;
    logic [15:0] r_window_q8;
    logic [18:0] r_rto_ms;
    logic [15:0] r_rtt_ms;
    logic        advance;
    logic        in_accept;

    // Handshake
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.add_step        <= ADD_STEP_RST;
            r_cfg.decrease_shift  <= DECREASE_SHIFT_RST;
            r_cfg.window_bound    <= WINDOW_BOUND_RST;
            r_cfg.first_rto_floor <= FIRST_RTO_FLOOR_RST;
            r_cfg.later_rto_floor <= LATER_RTO_FLOOR_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ADD_STEP:        r_cfg.add_step        <= i_cfg_wr_data[7:0];
                CFG_DECREASE_SHIFT:  r_cfg.decrease_shift  <= i_cfg_wr_data[2:0];
                CFG_WINDOW_BOUND:    r_cfg.window_bound    <= i_cfg_wr_data[7:0];
                CFG_FIRST_RTO_FLOOR: r_cfg.first_rto_floor <= i_cfg_wr_data;
                CFG_LATER_RTO_FLOOR: r_cfg.later_rto_floor <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_kind      <= i_kind;
            r_send_time <= i_send_time;
            r_now_time  <= i_now_time;
        end
    end

    // Next-state logic
    aimdrto_core u_core (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_kind      (r_kind),
        .i_send_time (r_send_time),
        .i_now_time  (r_now_time),
        .o_state     (n_state)
    );

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.window        <= WIN_ONE;
            r_state.last_rtt      <= '0;
            r_state.smoothed_rtt  <= '0;
            r_state.rtt_variance  <= '0;
            r_state.timeout_value <= '0;
            r_state.first_update  <= 1'b1;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_window_q8 <= n_state.window;
            r_rto_ms    <= n_state.timeout_value[26:8];
            r_rtt_ms    <= n_state.last_rtt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_window_q8 = r_window_q8;
    assign o_rto_ms    = r_rto_ms;
    assign o_rtt_ms    = r_rtt_ms;

endmodule

// ===== hw/rtl/aimdrto_checker.sv =====
// ----------------------------------------------------------------------------
// aimdrto_checker
// Port-level checks for the AIMD window / RTO estimator.
// ----------------------------------------------------------------------------
module aimdrto_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_window_q8,
    input logic [18:0] o_rto_ms,
    input logic [15:0] o_rtt_ms
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_window_q8)
            && $stable(o_rto_ms) && $stable(o_rtt_ms))
        else $error("result changed while stalled");

    // Window never drops below one datagram
    a_window_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_window_q8 >= 16'd256)
        else $error("window below 1.0");

    // Input is stalled only by a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // An accepted transaction leaves a result pending once it has passed the input register
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##1 o_out_valid)
        else $error("accepted transaction produced no result");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind aimd_window_rto_estimator aimdrto_checker u_aimdrto_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_window_q8 (o_window_q8),
    .o_rto_ms    (o_rto_ms),
    .o_rtt_ms    (o_rtt_ms)
);
